// ===== rtl/core/tgc_pkg.sv =====
// tgc_pkg: shared types and constants for the touch gesture classifier.
// Used by tgc_front, tgc_queue, tgc_back and touch_gesture_classifier.
package tgc_pkg;

    localparam int unsigned COORD_W   = 12;
    localparam int unsigned DELTA_W   = COORD_W + 1;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DZ_W      = 12;
    localparam int unsigned LPT_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned S_DATA_W  = 72;
    localparam int unsigned M_DATA_W  = 32;

    localparam logic [3:0] FINGER_MASK = 4'hF;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_EN   = 2'd2;

    localparam logic [DZ_W-1:0]  DEAD_ZONE_RST  = 12'd20;
    localparam logic [LPT_W-1:0] LONG_PRESS_RST = 16'd500;

    typedef enum logic [2:0] {
        GEST_TAP        = 3'd0,
        GEST_LONG_PRESS = 3'd1,
        GEST_LEFT       = 3'd2,
        GEST_RIGHT      = 3'd3,
        GEST_UP         = 3'd4,
        GEST_DOWN       = 3'd5
    } gesture_t;

    typedef struct packed {
        logic [DZ_W-1:0]  dead_zone;
        logic [LPT_W-1:0] long_press_time;
        logic             events_enable;
    } cfg_t;

    // one finished touch, movement as two's complement
    typedef struct packed {
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        logic [TIME_W-1:0]  elapsed;
        logic [COORD_W-1:0] begin_x;
        logic [COORD_W-1:0] begin_y;
    } release_t;

endpackage

// ===== rtl/core/tgc_front.sv =====
// tgc_front: accepts polls, tracks the touch and pushes one record per release while events are enabled.
// Depends on tgc_pkg.
module tgc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    poll_accept,
    input  logic                    read_ok,
    input  logic [7:0]              status_byte,
    input  logic [7:0]              x_high,
    input  logic [7:0]              x_low,
    input  logic [7:0]              y_high,
    input  logic [7:0]              y_low,
    input  logic [tgc_pkg::TIME_W-1:0] now_ms,
    input  logic                    events_enable,
    output logic                    push,
    output tgc_pkg::release_t       push_data
);

    logic                        tracking_reg, tracking_next;
    logic [tgc_pkg::COORD_W-1:0] begin_x_reg, begin_y_reg, latest_x_reg, latest_y_reg;
    logic [tgc_pkg::TIME_W-1:0]  begin_time_reg;
    logic                        touched;
    logic [tgc_pkg::COORD_W-1:0] x_pt, y_pt;

    assign touched = read_ok && ((status_byte[3:0] & tgc_pkg::FINGER_MASK) != 4'd0);
    assign x_pt    = {x_high[3:0], x_low};
    assign y_pt    = {y_high[3:0], y_low};

    always_comb begin
        tracking_next = tracking_reg;
        push          = 1'b0;
        if (poll_accept) begin
            if (touched) begin
                tracking_next = 1'b1;
            end else if (tracking_reg) begin
                tracking_next = 1'b0;
                push          = events_enable;
            end
        end
    end

    assign push_data.dx      = {1'b0, latest_x_reg} - {1'b0, begin_x_reg};
    assign push_data.dy      = {1'b0, latest_y_reg} - {1'b0, begin_y_reg};
    assign push_data.elapsed = now_ms - begin_time_reg;
    assign push_data.begin_x = begin_x_reg;
    assign push_data.begin_y = begin_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg <= 1'b0;
        end else begin
            tracking_reg <= tracking_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (poll_accept && touched) begin
            if (!tracking_reg) begin
                begin_x_reg    <= x_pt;
                begin_y_reg    <= y_pt;
                begin_time_reg <= now_ms;
            end
            latest_x_reg <= x_pt;
            latest_y_reg <= y_pt;
        end
    end

    // a release record only leaves a tracked touch
    a_push_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> tracking_reg && !tracking_next)
        else $error("release pushed without a tracked touch");

endmodule

// ===== rtl/core/tgc_queue.sv =====
// tgc_queue: small FIFO of release records between front and back.
// Depends on tgc_pkg.
module tgc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tgc_pkg::release_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tgc_pkg::release_t head_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tgc_pkg::release_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full release queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("release queue count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");

endmodule

// ===== rtl/core/tgc_back.sv =====
// tgc_back: classifies queued releases and holds the event in the output register.
// Depends on tgc_pkg.
module tgc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  tgc_pkg::release_t           head_data,
    output logic                        pop,
    input  logic [tgc_pkg::DZ_W-1:0]    dead_zone,
    input  logic [tgc_pkg::LPT_W-1:0]   long_press_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tgc_pkg::gesture_t           gesture,
    output logic [tgc_pkg::COORD_W-1:0] origin_x,
    output logic [tgc_pkg::COORD_W-1:0] origin_y
);

    logic                        out_valid_reg;
    tgc_pkg::gesture_t           gesture_reg, gesture_next;
    logic [tgc_pkg::COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [tgc_pkg::DELTA_W-1:0] ax, ay;
    logic                        neg_x, neg_y, still, horiz, held;

    assign pop   = head_valid && (!out_valid_reg || out_ready);
    assign neg_x = head_data.dx[tgc_pkg::DELTA_W-1];
    assign neg_y = head_data.dy[tgc_pkg::DELTA_W-1];
    assign ax    = neg_x ? (~head_data.dx + tgc_pkg::DELTA_W'(1)) : head_data.dx;
    assign ay    = neg_y ? (~head_data.dy + tgc_pkg::DELTA_W'(1)) : head_data.dy;
    assign still = (ax < {1'b0, dead_zone}) && (ay < {1'b0, dead_zone});
    assign horiz = ax > ay;
    assign held  = head_data.elapsed >= {16'd0, long_press_time};

    always_comb begin
        if (still) begin
            gesture_next = held ? tgc_pkg::GEST_LONG_PRESS : tgc_pkg::GEST_TAP;
        end else if (horiz) begin
            gesture_next = neg_x ? tgc_pkg::GEST_LEFT : tgc_pkg::GEST_RIGHT;
        end else begin
            gesture_next = neg_y ? tgc_pkg::GEST_UP : tgc_pkg::GEST_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            gesture_reg  <= gesture_next;
            origin_x_reg <= head_data.begin_x;
            origin_y_reg <= head_data.begin_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;
    assign origin_x  = origin_x_reg;
    assign origin_y  = origin_y_reg;

    // a waiting event is never overwritten
    a_hold_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("pending event overwritten");

endmodule

// ===== rtl/core/touch_gesture_classifier.sv =====
// touch_gesture_classifier: tap / long press / swipe events from touch polls.
// An event leaves on m_axis after its release record has passed the release queue and the event output register.
// Throughput: one poll per cycle; s_axis_tready drops only while the release queue is full.
// The release queue (QUEUE_DEPTH entries) and the event output register part the two sides.
// Reset (aresetn low, synchronous): tracking off, queue and output empty, config to defaults.
// Depends on tgc_pkg, tgc_front, tgc_queue, tgc_back.
module touch_gesture_classifier #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // status_byte[7:0], x_high[15:8], x_low[23:16], y_high[31:24], y_low[39:32],
    // now_ms[71:40]
    input  logic [tgc_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // read_ok[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // gesture[2:0], origin_x[14:3], origin_y[26:15], zero[31:27]
    output logic [tgc_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgc_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

    tgc_pkg::cfg_t               cfg_reg;
    tgc_pkg::release_t           push_data, head_data;
    tgc_pkg::gesture_t           gesture;
    logic                        push, full, pop, head_valid, poll_accept;
    logic [tgc_pkg::COORD_W-1:0] origin_x, origin_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_zone       <= tgc_pkg::DEAD_ZONE_RST;
            cfg_reg.long_press_time <= tgc_pkg::LONG_PRESS_RST;
            cfg_reg.events_enable   <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                tgc_pkg::CFG_DEAD_ZONE:  cfg_reg.dead_zone       <= cfg_wdata[tgc_pkg::DZ_W-1:0];
                tgc_pkg::CFG_LONG_PRESS: cfg_reg.long_press_time <= cfg_wdata;
                tgc_pkg::CFG_EVENTS_EN:  cfg_reg.events_enable   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign poll_accept   = s_axis_tvalid && !full;

    tgc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .poll_accept   (poll_accept),
        .read_ok       (s_axis_tuser),
        .status_byte   (s_axis_tdata[7:0]),
        .x_high        (s_axis_tdata[15:8]),
        .x_low         (s_axis_tdata[23:16]),
        .y_high        (s_axis_tdata[31:24]),
        .y_low         (s_axis_tdata[39:32]),
        .now_ms        (s_axis_tdata[71:40]),
        .events_enable (cfg_reg.events_enable),
        .push          (push),
        .push_data     (push_data)
    );

    tgc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tgc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_data       (head_data),
        .pop             (pop),
        .dead_zone       (cfg_reg.dead_zone),
        .long_press_time (cfg_reg.long_press_time),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .gesture         (gesture),
        .origin_x        (origin_x),
        .origin_y        (origin_y)
    );

    assign m_axis_tdata = {5'd0, origin_y, origin_x, gesture};

endmodule

// ===== test/tgc_event_checker.sv =====
// tgc_event_checker: watches the poll, event and config ports of touch_gesture_classifier,
// predicts each gesture event from the accepted polls and compares it field by field.
// Depends on tgc_pkg for the gesture codes, config indexes and bus widths.
module tgc_event_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [tgc_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [tgc_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgc_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             events_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        tgc_pkg::gesture_t           gesture;
        logic [tgc_pkg::COORD_W-1:0] origin_x;
        logic [tgc_pkg::COORD_W-1:0] origin_y;
    } gesture_event_t;

    gesture_event_t     expected_events[$];

    logic [tgc_pkg::DZ_W-1:0]    dead_zone;
    logic [tgc_pkg::LPT_W-1:0]   long_press;
    logic                        events_on;
    logic                        tracking;
    logic [tgc_pkg::COORD_W-1:0] start_x, start_y, last_x, last_y;
    logic [tgc_pkg::TIME_W-1:0]  start_ms;
    int                          mismatches = 0;
    int                          seen = 0;

    initial begin
        fail_count     = 0;
        pending        = 0;
        events_checked = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (mismatches < 30)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic tgc_pkg::gesture_t classify_touch(input int dx, input int dy,
                                                         input logic [tgc_pkg::TIME_W-1:0] held);
        int ax, ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax < int'(dead_zone) && ay < int'(dead_zone))
            return (held >= tgc_pkg::TIME_W'(long_press)) ? tgc_pkg::GEST_LONG_PRESS
                                                           : tgc_pkg::GEST_TAP;
        if (ax > ay)
            return (dx < 0) ? tgc_pkg::GEST_LEFT : tgc_pkg::GEST_RIGHT;
        return (dy < 0) ? tgc_pkg::GEST_UP : tgc_pkg::GEST_DOWN;
    endfunction

    always @(posedge aclk) begin : monitor
        logic                        touched;
        logic [tgc_pkg::COORD_W-1:0] px, py;
        logic [tgc_pkg::TIME_W-1:0]  ms;
        gesture_event_t              want;

        if (!aresetn) begin
            dead_zone  = tgc_pkg::DEAD_ZONE_RST;
            long_press = tgc_pkg::LONG_PRESS_RST;
            events_on  = 1'b1;
            tracking   = 1'b0;
            start_x    = '0;
            start_y    = '0;
            last_x     = '0;
            last_y     = '0;
            start_ms   = '0;
            expected_events.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    tgc_pkg::CFG_DEAD_ZONE:  dead_zone  = cfg_wdata[tgc_pkg::DZ_W-1:0];
                    tgc_pkg::CFG_LONG_PRESS: long_press = cfg_wdata[tgc_pkg::LPT_W-1:0];
                    tgc_pkg::CFG_EVENTS_EN:  events_on  = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                touched = s_axis_tuser &&
                          ((s_axis_tdata[7:0] & {4'h0, tgc_pkg::FINGER_MASK}) != 8'h00);
                px = {s_axis_tdata[11:8], s_axis_tdata[23:16]};
                py = {s_axis_tdata[27:24], s_axis_tdata[39:32]};
                ms = s_axis_tdata[71:40];
                if (touched) begin
                    if (!tracking) begin
                        tracking = 1'b1;
                        start_x  = px;
                        start_y  = py;
                        start_ms = ms;
                    end
                    last_x = px;
                    last_y = py;
                end else if (tracking) begin
                    tracking = 1'b0;
                    if (events_on) begin
                        want.gesture  = classify_touch(int'(last_x) - int'(start_x),
                                                       int'(last_y) - int'(start_y),
                                                       ms - start_ms);
                        want.origin_x = start_x;
                        want.origin_y = start_y;
                        expected_events.push_back(want);
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    report("unexpected event", m_axis_tdata, 32'd0);
                end else begin
                    want = expected_events.pop_front();
                    seen++;
                    if (m_axis_tdata[2:0] !== want.gesture)
                        report("gesture", 32'(m_axis_tdata[2:0]), 32'(want.gesture));
                    if (m_axis_tdata[14:3] !== want.origin_x)
                        report("origin_x", 32'(m_axis_tdata[14:3]), 32'(want.origin_x));
                    if (m_axis_tdata[26:15] !== want.origin_y)
                        report("origin_y", 32'(m_axis_tdata[26:15]), 32'(want.origin_y));
                    if (m_axis_tdata[31:27] !== 5'd0)
                        report("padding", 32'(m_axis_tdata[31:27]), 32'd0);
                end
            end
        end

        fail_count     <= mismatches;
        pending        <= expected_events.size();
        events_checked <= seen;
    end

endmodule

// ===== test/tb.sv =====
// tb: drives touch polls and config writes into touch_gesture_classifier under varying
// back-pressure; tgc_event_checker predicts and compares the gesture events.
// Depends on tgc_pkg, touch_gesture_classifier and tgc_event_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tgc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASE_POLLS = 325;
    localparam int CYCLE_LIMIT = 400_000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tgc_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [tgc_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic                           cfg_we = 1'b0;
    logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tgc_pkg::CFG_DAT_W-1:0]  cfg_wdata = '0;

    int fail_count, pending, events_checked;
    int tx_idle = 0;
    int rx_idle = 0;
    int polls_sent = 0;
    int cycle_count = 0;
    int cur_dz = 20;
    int cur_lpt = 500;

    touch_gesture_classifier u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    tgc_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .events_checked (events_checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_poll(input logic ok, input logic [7:0] status,
                             input logic [7:0] xh, input logic [7:0] xl,
                             input logic [7:0] yh, input logic [7:0] yl,
                             input logic [31:0] ms);
        if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ok;
        s_axis_tdata  <= {ms, yl, yh, xl, xh, status};
        do @(posedge aclk); while (!s_axis_tready);
        polls_sent++;
    endtask

    task automatic touch_at(input logic [11:0] x, input logic [11:0] y, input logic [31:0] ms);
        logic [3:0] fingers, junk_s, junk_x, junk_y;
        fingers = 4'($urandom_range(15, 1));
        junk_s  = 4'($urandom_range(15));
        junk_x  = 4'($urandom_range(15));
        junk_y  = 4'($urandom_range(15));
        send_poll(1'b1, {junk_s, fingers}, {junk_x, x[11:8]}, x[7:0], {junk_y, y[11:8]},
                  y[7:0], ms);
    endtask

    task automatic release_at(input logic [31:0] ms);
        logic [3:0] junk_s;
        junk_s = 4'($urandom_range(15));
        if ($urandom_range(1))
            send_poll(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), ms);
        else
            send_poll(1'b1, {junk_s, 4'h0}, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), ms);
    endtask

    task automatic gesture_run(input logic [11:0] x0, input logic [11:0] y0,
                               input logic [11:0] x1, input logic [11:0] y1,
                               input logic [31:0] t0, input logic [31:0] held);
        touch_at(x0, y0, t0);
        touch_at(x1, y1, t0 + 1);
        release_at(t0 + held);
    endtask

    function automatic int clamp12(input int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 4095;
            default: return int'($urandom_range(4095));
        endcase
    endfunction

    task automatic random_touch();
        int x0, y0, dx, dy, span, d, n;
        logic [31:0] t0, held;
        x0   = pick_coord();
        y0   = pick_coord();
        span = cur_dz + 2;
        case ($urandom_range(3))
            0: begin
                dx = int'($urandom_range(2 * span)) - span;
                dy = int'($urandom_range(2 * span)) - span;
            end
            1: begin
                d  = int'($urandom_range(600));
                dx = $urandom_range(1) ? d : -d;
                dy = $urandom_range(1) ? d : -d;
            end
            2: begin
                dx = int'($urandom_range(4095)) - x0;
                dy = int'($urandom_range(4095)) - y0;
            end
            default: begin
                dx = 0;
                dy = 0;
            end
        endcase
        case ($urandom_range(3))
            0:       held = cur_lpt - 1 + $urandom_range(2);
            1:       held = $urandom_range(2000);
            2:       held = $urandom;
            default: held = $urandom_range(2 * cur_lpt + 2);
        endcase
        t0 = $urandom;
        n  = int'($urandom_range(4, 1));
        touch_at(12'(x0), 12'(y0), t0);
        for (int i = 1; i < n - 1; i++)
            touch_at(12'($urandom_range(4095)), 12'($urandom_range(4095)), t0 + i);
        if (n >= 2)
            touch_at(12'(clamp12(x0 + dx)), 12'(clamp12(y0 + dy)), t0 + n);
        release_at(t0 + held);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tgc_pkg::CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] dz_word, input logic [15:0] lpt_word,
                              input logic [15:0] en_word);
        write_reg(tgc_pkg::CFG_DEAD_ZONE, dz_word);
        write_reg(tgc_pkg::CFG_LONG_PRESS, lpt_word);
        write_reg(tgc_pkg::CFG_EVENTS_EN, en_word);
        cfg_we  <= 1'b0;
        cur_dz  = int'(dz_word[11:0]);
        cur_lpt = int'(lpt_word);
        @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle = 29;
        rx_idle = 66;
        send_poll(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_poll(1'b1, 8'hF0, 8'h12, 8'h34, 8'h56, 8'h78, 32'd10);
        send_poll(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0);
        send_poll(1'b0, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 32'd499);
        gesture_run(0, 0, 19, 19, 32'hFFFF_FE00, 500);
        gesture_run(2000, 2000, 1000, 2100, 32'd1000, 120);
        gesture_run(0, 0, 4095, 4094, 32'd5000, 80);
        gesture_run(2000, 2000, 2010, 0, 32'd7000, 60);
        gesture_run(100, 100, 200, 200, 32'd9000, 40);
        gesture_run(300, 300, 400, 200, 32'd9500, 900);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            tx_idle = (phase < 2) ? 29 : ((phase < 4) ? 66 : 0);
            rx_idle = (phase < 2) ? 66 : ((phase < 4) ? 29 : 0);
            case (phase)
                1: begin
                    write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
                    set_config(16'd0, 16'd0, 16'd1);
                end
                2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_config(16'($urandom_range(100, 1)), 16'($urandom_range(1500)), 16'hFFFE);
                4: set_config(16'($urandom_range(100, 1)), 16'($urandom_range(1500)), 16'd1);
                5: set_config(16'd1, 16'd1, 16'd1);
                default: ;
            endcase
            while (polls_sent < 22 + (phase + 1) * PHASE_POLLS) begin
                if ($urandom_range(99) < 15)
                    send_poll(1'($urandom_range(1)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)),
                              $urandom);
                else
                    random_touch();
            end
        end
        drain();

        $display("covered %0d polls over six register settings and three idle patterns,",
                 polls_sent);
        $display("with %0d gesture events compared in %0d cycles", events_checked, cycle_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
